// ----- sv/mersenne_twister_prng_macros.svh -----
// assertion macros for the mersenne twister generator
`ifndef MERSENNE_TWISTER_PRNG_MACROS_SVH
`define MERSENNE_TWISTER_PRNG_MACROS_SVH

// same-cycle implication, disabled during reset
`define MTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/mtp_pkg.sv -----
// types, constants and functions shared by the mersenne twister generator
package mtp_pkg;

   localparam int unsigned STATE_WORDS  = 624;
   localparam int unsigned TWIST_OFFSET = 397;
   localparam int unsigned IDX_W        = $clog2(STATE_WORDS);
   localparam int unsigned WORD_W       = 32;

   localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(STATE_WORDS - 1);
   localparam logic [IDX_W-1:0]  TWIST_STEP   = IDX_W'(TWIST_OFFSET);
   localparam logic [IDX_W-1:0]  WRAP_WORDS   = IDX_W'(STATE_WORDS);
   localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
   localparam logic [WORD_W-1:0] SEED_RESET   = 32'd4357;
   localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
   localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
   localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
   localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
   localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_READ,
      ST_CALC
   } fsm_state_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr_a;
      logic [IDX_W-1:0] rd_addr_b;
   } store_ctl_type;

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
      logic [WORD_W-1:0] y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                     input logic [WORD_W-1:0] nxt,
                                                     input logic [WORD_W-1:0] far);
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] mag;
      y   = (cur & HIGH_BIT) | (nxt & LOW_BITS);
      mag = y[0] ? TWIST_MATRIX : '0;
      return far ^ (y >> 1) ^ mag;
   endfunction

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] k);
      return (k == LAST_IDX) ? '0 : k + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] far_idx(input logic [IDX_W-1:0] k);
      logic [IDX_W-1:0] s;
      s = k + TWIST_STEP;
      return (s >= WRAP_WORDS) ? s - WRAP_WORDS : s;
   endfunction

endpackage

// ----- sv/mtp_store.sv -----
// state word store: one write port, two registered read ports
module mtp_store (
   input  logic                  clock,
   input  mtp_pkg::store_ctl_type ctl,
   input  logic [31:0]           wr_data,
   output logic [31:0]           rd_data_a,
   output logic [31:0]           rd_data_b
);
   import mtp_pkg::*;

   logic [WORD_W-1:0] mem [STATE_WORDS];
   logic [WORD_W-1:0] rd_a_ff;
   logic [WORD_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_a_ff <= mem[ctl.rd_addr_a];
         rd_b_ff <= mem[ctl.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- sv/mersenne_twister_prng.sv -----
// mersenne twister generator: one tempered 32-bit word per request transaction
// on acceptance the store read is issued; ST_CALC then twists, writes back and registers the
// tempered result once the output is free; no new request is taken until the block is idle again
// reseed (restart or first request after reset) first does 624 store writes, then one read
// reset clears control only; the store is left as is and seeded on the first request
module mersenne_twister_prng (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,   // seed_value
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [0] restart, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata      // [31:0] random_word
);
   import mtp_pkg::*;

   `include "mersenne_twister_prng_macros.svh"

   fsm_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] seed_word_ff, seed_word_in;
   logic [WORD_W-1:0] hold_ff, hold_in;
   logic              seeded_ff, seeded_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [WORD_W-1:0] seed_value_ff;

   store_ctl_type     store_ctl;
   logic [WORD_W-1:0] store_wr_data;
   logic [WORD_W-1:0] rd_a;
   logic [WORD_W-1:0] rd_b;
   logic [WORD_W-1:0] new_word;
   logic              req_accept;
   logic              need_seed;
   logic              out_free;

   mtp_store u_store (
      .clock     (clock),
      .ctl       (store_ctl),
      .wr_data   (store_wr_data),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign need_seed  = req_tdata[0] || !seeded_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign new_word   = twist_word(hold_ff, rd_a, rd_b);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = need_seed ? ST_SEED : ST_CALC;
            end
         end
         ST_SEED: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_CALC;
         ST_CALC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      seed_word_in  = seed_word_ff;
      hold_in       = hold_ff;
      seeded_in     = seeded_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      store_ctl     = '0;
      store_wr_data = new_word;
      store_ctl.rd_addr_a = next_idx(idx_ff);
      store_ctl.rd_addr_b = far_idx(idx_ff);
      store_ctl.wr_addr   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (need_seed) begin
                  seed_word_in = seed_value_ff;
                  cnt_in       = '0;
               end else begin
                  store_ctl.rd_en = 1'b1;
               end
            end
         end
         ST_SEED: begin
            store_ctl.wr_en   = 1'b1;
            store_ctl.wr_addr = cnt_ff;
            store_wr_data     = seed_word_ff;
            seed_word_in      = seed_word_ff * SEED_MULT;
            cnt_in            = cnt_ff + IDX_W'(1);
            if (cnt_ff == '0) begin
               hold_in = seed_word_ff;
            end
            if (cnt_ff == LAST_IDX) begin
               idx_in    = '0;
               seeded_in = 1'b1;
            end
         end
         ST_READ: begin
            store_ctl.rd_en = 1'b1;
         end
         ST_CALC: begin
            if (out_free) begin
               store_ctl.wr_en = 1'b1;
               hold_in         = rd_a;
               idx_in          = next_idx(idx_ff);
               rsp_valid_in    = 1'b1;
               rsp_data_in     = temper(new_word);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         seeded_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         seed_value_ff <= SEED_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            seed_value_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      seed_word_ff <= seed_word_in;
      hold_ff      <= hold_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `MTP_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !store_ctl.wr_en, "store written while idle")
   `MTP_ASSERT_NOW(a_idx_range, clock, reset, 1'b1, idx_ff <= LAST_IDX, "read index out of range")
   `MTP_ASSERT_NEXT(a_seed_done, clock, reset, state_ff == ST_SEED && cnt_ff == LAST_IDX, state_ff == ST_READ && seeded_ff && idx_ff == '0, "seeding did not finish into read")
   `MTP_ASSERT_NEXT(a_restart_seeds, clock, reset, req_tvalid && req_tready && req_tdata[0], state_ff == ST_SEED && cnt_ff == '0, "restart did not start seeding")
   `MTP_ASSERT_NEXT(a_calc_result, clock, reset, state_ff == ST_CALC && out_free, rsp_tvalid && state_ff == ST_IDLE, "twist step gave no result")

endmodule
